// ----- hdl/mbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mbr_pkg;

	// Field widths of the request and result words.
	localparam int OPCODE_W = 1;
	localparam int PIXEL_ADDR_W = 9;
	localparam int PIXEL_W = 16;
	localparam int COORD_W = 19;
	localparam int DEPTH_W = 16;
	localparam int VALUE_W = 24;
	localparam int OUT_FRAC = 8;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIM_W = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_MASK_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 10'd512;

	localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b1;

	// Four neighbors of a sample, bit 0 selects the right column, bit 1 the lower row.
	typedef logic [1:0] tap_t;
	localparam tap_t TAP_LAST = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic issue;
		tap_t tap;
		logic clear;
		logic wr_en;
	} blend_ctrl_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} blend_stat_t;

endpackage

`default_nettype wire

// ----- hdl/mbr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mbr_req_if;
	logic valid;
	logic ready;
	logic [mbr_pkg::OPCODE_W-1:0] opcode;
	logic [mbr_pkg::PIXEL_ADDR_W-1:0] pixel_column;
	logic [mbr_pkg::PIXEL_ADDR_W-1:0] pixel_row;
	logic [mbr_pkg::PIXEL_W-1:0] pixel_value;
	logic signed [mbr_pkg::COORD_W-1:0] sample_x;
	logic signed [mbr_pkg::COORD_W-1:0] sample_y;
	logic signed [mbr_pkg::DEPTH_W-1:0] sample_depth;

	modport source (
		output valid, opcode, pixel_column, pixel_row, pixel_value,
		output sample_x, sample_y, sample_depth,
		input ready
	);
	modport sink (
		input valid, opcode, pixel_column, pixel_row, pixel_value,
		input sample_x, sample_y, sample_depth,
		output ready
	);
endinterface

interface mbr_res_if;
	logic valid;
	logic ready;
	logic [mbr_pkg::VALUE_W-1:0] sample_value;
	logic covered;

	modport source (output valid, sample_value, covered, input ready);
	modport sink (input valid, sample_value, covered, output ready);
endinterface

`default_nettype wire

// ----- hdl/mbr_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbr_blend #(
	parameter int FRACTION_BITS = 8,
	parameter int ADDR_W = 18,
	parameter int DEPTH = 262144
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mbr_pkg::blend_ctrl_t ctrl,
	input wire logic [ADDR_W-1:0] wr_addr,
	input wire logic [mbr_pkg::PIXEL_W-1:0] wr_data,
	input wire logic [ADDR_W-1:0] rd_addr,
	input wire logic [FRACTION_BITS-1:0] dx,
	input wire logic [FRACTION_BITS-1:0] dy,
	output mbr_pkg::blend_stat_t stat,
	output logic [mbr_pkg::PIXEL_W+2*FRACTION_BITS-1:0] acc
);
	import mbr_pkg::*;

	localparam int W_W = FRACTION_BITS + 1;
	localparam int WT_W = 2 * FRACTION_BITS + 1;
	localparam int ACC_W = PIXEL_W + 2 * FRACTION_BITS;
	localparam logic [W_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	logic [PIXEL_W-1:0] mem [DEPTH];

	logic [PIXEL_W-1:0] rd_data_s1;
	logic [WT_W-1:0] weight_s1;
	logic v_s1;
	logic [ACC_W-1:0] prod_s2;
	logic v_s2;
	logic [ACC_W-1:0] acc_q;

	logic [W_W-1:0] wx;
	logic [W_W-1:0] wy;
	logic [2*W_W-1:0] weight_full;
	logic [ACC_W:0] prod_full;

	always_comb begin
		wx = ctrl.tap[0] ? {1'b0, dx} : ONE - {1'b0, dx};
		wy = ctrl.tap[1] ? {1'b0, dy} : ONE - {1'b0, dy};
		weight_full = wx * wy;
		prod_full = rd_data_s1 * weight_s1;
	end

	// Writes only happen while no read is in flight, so the ports never touch one entry at once.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.issue) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= weight_full[WT_W-1:0];
		prod_s2 <= prod_full[ACC_W-1:0];
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
		end
	end

	assign stat.v_s1 = v_s1;
	assign stat.v_s2 = v_s2;
	assign acc = acc_q;

endmodule

`default_nettype wire

// ----- hdl/masked_bilinear_resampler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport  Word
// req       sink     opcode, pixel_column, pixel_row, pixel_value, sample_x, sample_y, sample_depth
// res       source   sample_value, covered
// cfg_*     write    cfg_we, cfg_index, cfg_data (no read-back)
//
// A pixel write produces no result word. A covered sample makes four reads through the
// single read port of the image RAM, then multiplies and accumulates the four products.
// A masked or out-of-bounds sample reads nothing.
// The image RAM is not cleared at reset; pixels must be written before they are sampled.
// A request can be taken while a finished result waits in the output register.

module masked_bilinear_resampler #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS = 512,
	parameter int FRACTION_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	mbr_req_if.sink req,
	mbr_res_if.source res,
	input wire logic cfg_we,
	input wire logic [mbr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [mbr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mbr_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ACC_W = PIXEL_W + 2 * FRACTION_BITS;
	localparam int LIM_W = 13;
	localparam int CPOS_W = COORD_W - 1 - FRACTION_BITS;

	state_t state_q;
	state_t state_next;

	logic signed [DEPTH_W-1:0] thr_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	tap_t tap_q;
	logic [ADDR_W-1:0] base_q;
	logic [FRACTION_BITS-1:0] dx_q;
	logic [FRACTION_BITS-1:0] dy_q;
	logic cov_q;

	logic out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic out_cov_q;

	logic accept;
	logic sample_acc;
	logic load_out;
	logic cov_now;
	logic [LIM_W-1:0] w_lim;
	logic [LIM_W-1:0] h_lim;
	logic [CPOS_W-1:0] x0;
	logic [CPOS_W-1:0] y0;
	logic [ADDR_W-1:0] base_now;
	logic [ADDR_W-1:0] wr_addr;
	logic wr_in_range;
	logic [ADDR_W-1:0] rd_addr;

	blend_ctrl_t ctrl;
	blend_stat_t stat;
	logic [ACC_W-1:0] acc;

	assign accept = req.valid && req.ready;
	assign sample_acc = accept && (req.opcode == OP_SAMPLE);

	// Coverage test and neighborhood base address, decided in the accept cycle.
	always_comb begin
		w_lim = (32'(width_q) > 32'(MAX_COLUMNS)) ? LIM_W'(MAX_COLUMNS) : LIM_W'(width_q);
		h_lim = (32'(height_q) > 32'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : LIM_W'(height_q);
		x0 = req.sample_x[COORD_W-2:FRACTION_BITS];
		y0 = req.sample_y[COORD_W-2:FRACTION_BITS];
		// The floor drops the sign bit, so a negative coordinate is rejected by its sign bit instead.
		cov_now = (req.sample_depth > thr_q)
			&& !req.sample_x[COORD_W-1] && !req.sample_y[COORD_W-1]
			&& (32'(x0) + 32'd1 < 32'(w_lim))
			&& (32'(y0) + 32'd1 < 32'(h_lim));
		base_now = ADDR_W'(32'(y0) * 32'(MAX_COLUMNS) + 32'(x0));
		wr_in_range = (32'(req.pixel_column) < 32'(MAX_COLUMNS))
			&& (32'(req.pixel_row) < 32'(MAX_ROWS));
		wr_addr = ADDR_W'(32'(req.pixel_row) * 32'(MAX_COLUMNS) + 32'(req.pixel_column));
		rd_addr = base_q + (tap_q[1] ? ADDR_W'(MAX_COLUMNS) : '0) + ADDR_W'(tap_q[0]);
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (sample_acc) begin
					state_next = cov_now ? S_READ : S_DONE;
				end
			end
			S_READ: begin
				if (tap_q == TAP_LAST) begin
					state_next = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last product is added at the end of this cycle.
				if (stat.v_s2 && !stat.v_s1) begin
					state_next = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || res.ready) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		ctrl.issue = (state_q == S_READ);
		ctrl.tap = tap_q;
		ctrl.clear = sample_acc;
		ctrl.wr_en = accept && (req.opcode == OP_WRITE) && wr_in_range;
		load_out = (state_q == S_DONE) && (!out_valid_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q <= '0;
			out_valid_q <= 1'b0;
			thr_q <= '0;
			width_q <= DIM_RESET;
			height_q <= DIM_RESET;
		end else begin
			state_q <= state_next;
			if (sample_acc) begin
				tap_q <= '0;
			end else if (state_q == S_READ) begin
				tap_q <= tap_q + tap_t'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MASK_THRESHOLD: thr_q <= cfg_data;
					REG_IMAGE_WIDTH: width_q <= cfg_data[DIM_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			base_q <= base_now;
			dx_q <= req.sample_x[FRACTION_BITS-1:0];
			dy_q <= req.sample_y[FRACTION_BITS-1:0];
			cov_q <= cov_now;
		end
		if (load_out) begin
			// The accumulator is cleared on accept, so an uncovered sample reads zero.
			out_value_q <= acc[ACC_W-1:2*FRACTION_BITS-OUT_FRAC];
			out_cov_q <= cov_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.sample_value = out_value_q;
	assign res.covered = out_cov_q;

	mbr_blend #(
		.FRACTION_BITS(FRACTION_BITS),
		.ADDR_W(ADDR_W),
		.DEPTH(DEPTH)
	) u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.wr_addr(wr_addr),
		.wr_data(req.pixel_value),
		.rd_addr(rd_addr),
		.dx(dx_q),
		.dy(dy_q),
		.stat(stat),
		.acc(acc)
	);

endmodule

`default_nettype wire

// ----- hdl/mbr_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbr_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic [mbr_pkg::OPCODE_W-1:0] req_opcode,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic [mbr_pkg::VALUE_W-1:0] res_value,
	input wire logic res_covered
);
	import mbr_pkg::*;

	// A stalled result word stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_covered))
		else $error("result word changed while stalled");

	// An uncovered sample always reports zero.
	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_covered |-> res_value == '0)
		else $error("uncovered result carries a nonzero value");

	// A sample keeps the block busy for at least the cycle after it is taken.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == OP_SAMPLE |=> !req_ready)
		else $error("request taken right after a sample");

	// A pixel write produces no result word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && req_valid && req_ready && req_opcode == OP_WRITE |=> !res_valid)
		else $error("result appeared after a pixel write");

endmodule

bind masked_bilinear_resampler mbr_check u_mbr_check (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_opcode(req.opcode),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_value(res.sample_value),
	.res_covered(res.covered)
);

`default_nettype wire
